// ===== src/mbps_pkg.sv =====
// Package for the masked byte pattern search block.
// Holds sizes, register indexes and the configuration struct; no dependencies.
`default_nettype none
package mbps_pkg;

  // Pattern and offset sizes
  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 32;
  localparam int WIN_DEPTH   = PATTERN_MAX - 1;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

  // Fixed field widths
  localparam int ADDR_BITS   = 48;
  localparam int PLEN_BITS   = 5;
  localparam int CARE_BITS   = 16;
  localparam int PAT_BYTES   = 16;

  // Configuration port sizes
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_IDX_W   = 3;

  // Register indexes (byte address = 8 * index)
  localparam logic [REG_IDX_W-1:0] REG_PAT_LO = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HI = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CARE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PLEN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE   = 3'd4;

  // Current configuration seen by the datapath
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [CARE_BITS-1:0]      care_mask;
    logic [PLEN_BITS-1:0]      pattern_length;
    logic [ADDR_BITS-1:0]      region_base;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/mbps_cfg.sv =====
// Configuration register file on an APB-style port.
// Depends on mbps_pkg for register indexes and the cfg_t struct.
`default_nettype none
module mbps_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [mbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output mbps_pkg::cfg_t                       cfg
);

  logic [63:0]                        pat_lo_r;
  logic [63:0]                        pat_hi_r;
  logic [mbps_pkg::CARE_BITS-1:0]     care_r;
  logic [mbps_pkg::PLEN_BITS-1:0]     plen_r;
  logic [mbps_pkg::ADDR_BITS-1:0]     base_r;
  logic [mbps_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mbps_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write the addressed register; addresses past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= '0;
      plen_r   <= mbps_pkg::PLEN_BITS'(1);
      base_r   <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        mbps_pkg::REG_PAT_LO: pat_lo_r <= pwdata[63:0];
        mbps_pkg::REG_PAT_HI: pat_hi_r <= pwdata[63:0];
        mbps_pkg::REG_CARE:   care_r   <= pwdata[mbps_pkg::CARE_BITS-1:0];
        mbps_pkg::REG_PLEN:   plen_r   <= pwdata[mbps_pkg::PLEN_BITS-1:0];
        mbps_pkg::REG_BASE:   base_r   <= pwdata[mbps_pkg::ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      mbps_pkg::REG_PAT_LO: prdata = pat_lo_r;
      mbps_pkg::REG_PAT_HI: prdata = pat_hi_r;
      mbps_pkg::REG_CARE:   prdata = mbps_pkg::CFG_DATA_W'(care_r);
      mbps_pkg::REG_PLEN:   prdata = mbps_pkg::CFG_DATA_W'(plen_r);
      mbps_pkg::REG_BASE:   prdata = mbps_pkg::CFG_DATA_W'(base_r);
      default:              prdata = '0;
    endcase
  end

  assign cfg.pattern        = {pat_hi_r, pat_lo_r};
  assign cfg.care_mask      = care_r;
  assign cfg.pattern_length = plen_r;
  assign cfg.region_base    = base_r;

endmodule
`default_nettype wire

// ===== src/mbps_cell.sv =====
// One window cell: holds one past byte, passes it on to its neighbor and
// compares it against the pattern byte aligned to it. Uses no package items.
`default_nettype none
module mbps_cell (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pat_byte,
  input  wire logic       care,
  output logic      [7:0] byte_out,
  output logic            hit
);

  logic [7:0] byte_r;

  // Take the neighbor's byte on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  assign hit      = !care || (byte_r == pat_byte);

endmodule
`default_nettype wire

// ===== src/masked_byte_pattern_search.sv =====
// Masked byte pattern search: scans a byte stream for a pattern with
// don't-care positions and reports the first match address per region.
// Channels: in_* carries one byte per beat, in_tlast marks the region's
// final byte. out_* carries one result per region: out_tuser is the found
// flag, out_tdata the match address (region base plus first match offset,
// zero when nothing matched). Registers are written through the APB port;
// the user must write them only while the stream is idle; the block does not enforce it.
// Throughput: one byte per cycle. A row of window cells shifts the last
// PATTERN_MAX-1 bytes and compares them in parallel with the current byte,
// so each byte is resolved in the cycle it is accepted.
// Output: the result is registered and appears in the cycle after the final byte is accepted.
// Stall: the result waits in an output register; while it is held and
// out_tready is low, in_tready is low and the input stream stalls.
// Reset: registers return to their defaults (pattern length 1, others 0),
// the window, byte counter and match state clear, and no result is pending.
// The byte counter saturates at 2^OFFSET_BITS-1; past that no match is tested.
`default_nettype none
module masked_byte_pattern_search (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,  // [7:0] data_byte
  input  wire logic                            in_tlast,  // last_byte
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [47:0]                     out_tdata, // [47:0] match_address
  output logic                                 out_tuser, // [0] found
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [mbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  localparam int OB = mbps_pkg::OFFSET_BITS;
  localparam int LW = mbps_pkg::LEN_W;
  localparam int IW = mbps_pkg::IDX_W;
  localparam int WD = mbps_pkg::WIN_DEPTH;

  mbps_pkg::cfg_t cfg;

  logic           in_fire;
  logic [LW-1:0]  len_eff;
  logic [LW-1:0]  len_m1;
  logic [IW-1:0]  cur_idx;
  logic           cur_hit;
  logic           window_hit;
  logic           test_en;
  logic           new_match;
  logic [OB-1:0]  new_offset;

  logic [7:0]     win_byte [WD];
  logic           win_hit  [WD];
  logic [WD-1:0]  win_hit_vec;

  logic [OB-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic           latched_r, latched_nxt;
  logic [OB-1:0]  offset_r, offset_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r;
  logic [OB-1:0]  out_offset_r;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Clamp the pattern length to the window size
  always_comb begin
    if (cfg.pattern_length > mbps_pkg::PLEN_BITS'(mbps_pkg::PATTERN_MAX)) begin
      len_eff = LW'(mbps_pkg::PATTERN_MAX);
    end else begin
      len_eff = LW'(cfg.pattern_length);
    end
  end

  assign len_m1  = len_eff - LW'(1);
  assign cur_idx = IW'(len_m1);

  // The current byte lines up with the last pattern byte
  assign cur_hit = !cfg.care_mask[cur_idx] || (in_tdata == cfg.pattern[cur_idx]);

  // Row of window cells; cell w holds the byte w+1 beats back
  for (genvar w = 0; w < WD; w++) begin : g_cell
    logic [LW-1:0] pos;
    logic [IW-1:0] pidx;
    logic          in_range;
    logic [7:0]    byte_in;

    assign pos      = len_eff - LW'(2) - LW'(w);
    assign pidx     = IW'(pos);
    assign in_range = (LW'(w) + LW'(2)) <= len_eff;

    if (w == 0) begin : g_head
      assign byte_in = in_tdata;
    end else begin : g_link
      assign byte_in = win_byte[w-1];
    end

    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (in_fire),
      .byte_in  (byte_in),
      .pat_byte (cfg.pattern[pidx]),
      .care     (in_range & cfg.care_mask[pidx]),
      .byte_out (win_byte[w]),
      .hit      (win_hit[w])
    );

    assign win_hit_vec[w] = win_hit[w];
  end

  assign window_hit = cur_hit & (&win_hit_vec);

  // Test only while unsaturated, unlatched and with the whole pattern inside
  assign test_en    = !(&bytes_seen_r) && !latched_r && (len_eff != '0)
                      && (bytes_seen_r >= OB'(len_m1));
  assign new_match  = test_en & window_hit;
  assign new_offset = bytes_seen_r - OB'(len_m1);

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid & in_tready;

  // Advance the per-region state; clear it after the final byte
  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    latched_nxt    = latched_r;
    offset_nxt     = offset_r;
    if (in_fire) begin
      if (in_tlast) begin
        bytes_seen_nxt = '0;
        latched_nxt    = 1'b0;
        offset_nxt     = '0;
      end else begin
        if (!(&bytes_seen_r)) begin
          bytes_seen_nxt = bytes_seen_r + OB'(1);
        end
        if (new_match) begin
          latched_nxt = 1'b1;
          offset_nxt  = new_offset;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      latched_r    <= 1'b0;
      offset_r     <= '0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      latched_r    <= latched_nxt;
      offset_r     <= offset_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && in_tlast) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_found_r  <= latched_r | new_match;
      out_offset_r <= latched_r ? offset_r : new_offset;
    end
  end

  // Form the address from the held offset and the region base
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_found_r
                      ? (cfg.region_base + mbps_pkg::ADDR_BITS'(out_offset_r))
                      : '0;

endmodule
`default_nettype wire

// ===== tb/masked_byte_pattern_search_test.sv =====
`timescale 1ns / 100ps
// Testbench for masked_byte_pattern_search: streams byte regions, predicts the
// first-match result of every region and checks each result beat against it.
// Depends on mbps_pkg and the masked_byte_pattern_search RTL.
module masked_byte_pattern_search_test;
  import mbps_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int STALL_CYCLES  = 400;
  localparam int SETTING_ITEMS = 155;
  localparam logic [31:0] SEEN_LIMIT = '1;
  // Indexes past the last register; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {
    SET_ALL_ZERO_STRICT,
    SET_ALL_ONES_LOOSE,
    SET_OVERLONG,
    SET_RANDOM
  } setting_kind_t;

  typedef struct packed {
    logic                 found;
    logic [ADDR_BITS-1:0] addr;
  } scan_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [47:0]           out_tdata;
  logic                  out_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  masked_byte_pattern_search u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the registers
  logic [63:0]          shadow_pat_lo;
  logic [63:0]          shadow_pat_hi;
  logic [15:0]          shadow_care;
  logic [4:0]           shadow_plen;
  logic [ADDR_BITS-1:0] shadow_base;

  // Shadow copy of the per-region scan state
  logic [7:0]           scan_window [WIN_DEPTH];
  logic [31:0]          seen_count;
  logic                 hit_latched;
  logic [31:0]          hit_offset;

  scan_result_t pending_scans[$];
  int errors;
  int items_sent;
  int src_idle_pct;
  int sink_idle_pct;
  int cycle_count;
  int hold_left;
  bit hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] pat_byte(input int j);
    logic [127:0] pat;
    pat = {shadow_pat_hi, shadow_pat_lo};
    return pat[8*j +: 8];
  endfunction

  // Pattern length in use, clipped to the window size
  function automatic int eff_len();
    return (shadow_plen > PATTERN_MAX) ? PATTERN_MAX : int'(shadow_plen);
  endfunction

  function automatic void clear_region();
    foreach (scan_window[k]) scan_window[k] = 8'h00;
    seen_count  = '0;
    hit_latched = 1'b0;
    hit_offset  = '0;
  endfunction

  // Advance the shadow scan by one accepted byte; queue a result on the last one
  function automatic void scan_byte(input logic [7:0] data, input logic last);
    int           len;
    int           back;
    logic         hit;
    logic [7:0]   got;
    scan_result_t res;
    len = eff_len();
    if (seen_count != SEEN_LIMIT) begin
      if (!hit_latched && len != 0 && 33'(seen_count) + 33'd1 >= 33'(len)) begin
        hit = 1'b1;
        for (int j = 0; j < len; j++) begin
          back = len - 1 - j;
          got  = (back == 0) ? data : scan_window[(back > 0) ? back - 1 : 0];
          if (shadow_care[j] && got != pat_byte(j)) hit = 1'b0;
        end
        if (hit) begin
          hit_latched = 1'b1;
          hit_offset  = seen_count + 32'd1 - 32'(len);
        end
      end
      seen_count++;
    end
    for (int k = WIN_DEPTH - 1; k > 0; k--) scan_window[k] = scan_window[k-1];
    scan_window[0] = data;
    if (last) begin
      res.found = hit_latched;
      res.addr  = hit_latched ? shadow_base + ADDR_BITS'(hit_offset) : '0;
      pending_scans = {pending_scans, res};
      clear_region();
    end
  endfunction

  // Offer one byte, idling at random first, and wait for the beat
  task automatic send_byte(input logic [7:0] data, input logic last);
    @(negedge clk);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    scan_byte(data, last);
    items_sent++;
  endtask

  task automatic send_region(input byte_q_t beats);
    foreach (beats[i]) send_byte(beats[i], i == beats.size() - 1);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << 3;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PAT_LO: shadow_pat_lo = value;
      REG_PAT_HI: shadow_pat_hi = value;
      REG_CARE:   shadow_care   = value[15:0];
      REG_PLEN:   shadow_plen   = value[4:0];
      REG_BASE:   shadow_base   = value[ADDR_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [15:0] care, input logic [4:0] plen,
                               input logic [ADDR_BITS-1:0] base);
    write_reg(REG_PAT_LO, lo);
    write_reg(REG_PAT_HI, hi);
    write_reg(REG_CARE, 64'(care));
    write_reg(REG_PLEN, 64'(plen));
    write_reg(REG_BASE, 64'(base));
  endtask

  // Build a region from noise, mostly with the pattern planted in it,
  // sometimes with one byte of the planted span flipped
  task automatic send_random_region();
    byte_q_t beats;
    int      len;
    int      n;
    int      pos;
    int      j;
    len = eff_len();
    if ($urandom_range(19, 0) == 0) n = $urandom_range(120, 1);
    else n = $urandom_range(len * 2 + 6, 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 0)) beats = {beats, 8'($urandom)};
      else beats = {beats, pat_byte($urandom_range(PATTERN_MAX - 1, 0))};
    end
    if (len > 0 && n >= len && $urandom_range(99, 0) < 70) begin
      pos = $urandom_range(n - len, 0);
      for (int k = 0; k < len; k++) begin
        if (shadow_care[k]) beats[pos+k] = pat_byte(k);
      end
      if ($urandom_range(99, 0) < 25) begin
        j = $urandom_range(len - 1, 0);
        beats[pos+j] = beats[pos+j] ^ (8'h01 << $urandom_range(7, 0));
      end
    end
    send_region(beats);
  endtask

  // After reset: length 1 with no care bit matches the first byte
  task automatic test_reset_defaults();
    send_region('{8'h00, 8'hFF});
    settle();
  endtask

  // Match at offset 1 with the highest base: address wraps to zero
  task automatic test_exact_match_wrap();
    apply_setting(64'h0000_0000_5AA5_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h000F, 5'd4,
                  48'hFFFF_FFFF_FFFF);
    send_region('{8'h11, 8'h00, 8'hFF, 8'hA5, 8'h5A});
    settle();
  endtask

  // Region shorter than the pattern never matches
  task automatic test_short_region();
    send_region('{8'h00, 8'hFF, 8'hA5});
    settle();
  endtask

  // Empty pattern never matches
  task automatic test_zero_length();
    write_reg(REG_PLEN, 64'd0);
    send_region('{8'h00, 8'hFF});
    settle();
  endtask

  // Care bits past the pattern length have no effect
  task automatic test_care_above_length();
    write_reg(REG_PLEN, 64'd2);
    write_reg(REG_CARE, 64'h0000_0000_0000_FFFF);
    write_reg(REG_BASE, 64'h0000_0000_0000_0100);
    send_region('{8'hFF, 8'h00, 8'hFF});
    settle();
  endtask

  // Writes past the last register leave the setting alone
  task automatic test_spare_registers();
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    send_region('{8'hFF, 8'h00, 8'hFF});
    settle();
  endtask

  task automatic test_random_scan(input setting_kind_t kind);
    logic [63:0]          lo;
    logic [63:0]          hi;
    logic [15:0]          care;
    logic [4:0]           plen;
    logic [ADDR_BITS-1:0] base;
    int                   stop_at;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    care = 16'($urandom);
    plen = 5'($urandom_range(16, 1));
    base = ADDR_BITS'({$urandom, $urandom});
    case (kind)
      SET_ALL_ZERO_STRICT: begin
        lo   = '0;
        hi   = '0;
        care = '1;
        plen = 5'd16;
        base = '1;
      end
      SET_ALL_ONES_LOOSE: begin
        lo   = '1;
        hi   = '1;
        care = '0;
        plen = 5'd1;
        base = '0;
      end
      SET_OVERLONG: begin
        plen = 5'($urandom_range(31, 17));
      end
      default: begin
        if ($urandom_range(9, 0) == 0) care = '0;
        else if ($urandom_range(9, 0) == 0) care = '1;
        if ($urandom_range(9, 0) == 0) plen = 5'd0;
      end
    endcase
    apply_setting(lo, hi, care, plen, base);
    stop_at = items_sent + SETTING_ITEMS;
    while (items_sent < stop_at) send_random_region();
    settle();
  endtask

  // Receiver holds off for a long stretch while short regions keep coming
  task automatic test_output_backpressure();
    byte_q_t beats;
    hold_req = 1'b1;
    for (int r = 0; r < 40; r++) begin
      beats.delete();
      repeat ($urandom_range(3, 1)) beats = {beats, 8'($urandom)};
      send_region(beats);
    end
    settle();
  endtask

  // Receiver: random ready, or a counted hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = STALL_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_scans.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got found=%0b addr=%h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = pending_scans.pop_front();
        if (out_tuser !== want.found) begin
          errors++;
          $display("%0t: found mismatch: expected %0b, got %0b",
                   $time, want.found, out_tuser);
        end
        if (out_tdata !== want.addr) begin
          errors++;
          $display("%0t: match_address mismatch: expected %h, got %h",
                   $time, want.addr, out_tdata);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("masked_byte_pattern_search_test: FAIL");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'h00;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    items_sent    = 0;
    cycle_count   = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    src_idle_pct  = 12;
    sink_idle_pct = 63;
    shadow_pat_lo = '0;
    shadow_pat_hi = '0;
    shadow_care   = '0;
    shadow_plen   = 5'd1;
    shadow_base   = '0;
    clear_region();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_exact_match_wrap();
    test_short_region();
    test_zero_length();
    test_care_above_length();
    test_spare_registers();

    // Sender mostly busy, receiver often idle
    src_idle_pct  = 12;
    sink_idle_pct = 63;
    test_random_scan(SET_ALL_ZERO_STRICT);
    test_random_scan(SET_RANDOM);
    test_random_scan(SET_OVERLONG);

    // Sender often idle, receiver mostly ready
    src_idle_pct  = 63;
    sink_idle_pct = 12;
    test_random_scan(SET_ALL_ONES_LOOSE);
    test_random_scan(SET_RANDOM);
    test_random_scan(SET_RANDOM);

    // No idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_scan(SET_RANDOM);
    test_output_backpressure();
    test_random_scan(SET_OVERLONG);
    test_random_scan(SET_RANDOM);

    if (errors == 0) begin
      $display("masked_byte_pattern_search_test: PASS");
    end else begin
      $display("masked_byte_pattern_search_test: FAIL");
    end
    $finish;
  end

endmodule
